// ===== rtl/calendar_date_add_days_macros.svh =====
// Assertion macros used by the checker file
`ifndef CALENDAR_DATE_ADD_DAYS_MACROS_SVH
`define CALENDAR_DATE_ADD_DAYS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cad_pkg.sv =====
// Package: types, constants and helper functions for the date adder
package cad_pkg;

	localparam int unsigned DayW   = 5;
	localparam int unsigned MonthW = 4;
	localparam int unsigned YearW  = 14;
	localparam int unsigned CountW = 16;

	// Days in a 400-year cycle and the year offset that keeps shifted years positive
	localparam int unsigned EraDays   = 146097;
	localparam int unsigned EraYears  = 400;
	localparam int unsigned LastDoe   = 146096;

	// Reciprocal constants (value, shift)
	localparam int unsigned RecipDiv100  = 20972;  // >> 21, exact below 43690
	localparam int unsigned RecipEra     = 29398;  // >> 32, floor, may be one low
	localparam int unsigned RecipDiv365a = 45965;  // >> 24, exact below 2^20
	localparam int unsigned RecipDiv9131 = 29399;  // >> 28, exact below 39400
	localparam int unsigned RecipDiv365b = 183860; // >> 26, exact below 2^20
	localparam int unsigned RecipDiv100s = 41;     // >> 12, exact below 1024
	localparam int unsigned RecipDiv153  = 1714;   // >> 18, exact below 2674

	localparam logic [MonthW-1:0] MonFeb = 4'd2;
	localparam logic [MonthW-1:0] MonDec = 4'd12;

	// Pipeline payload; each stage fills in its fields, and later stages update era, doy and mp
	typedef struct packed {
		logic [DayW-1:0]   d0;
		logic [MonthW-1:0] m0;
		logic [YearW-1:0]  y0;
		logic [CountW-1:0] n;
		logic              ok;
		logic [7:0]        qy;
		logic [14:0]       yp;
		logic [3:0]        mp;
		logic [8:0]        doy;
		logic [7:0]        q100;
		logic [22:0]       nd;
		logic [5:0]        era;
		logic [18:0]       rem;
		logic [17:0]       doe;
		logic [6:0]        a;
		logic [2:0]        b;
		logic              c;
		logic [17:0]       t;
		logic [8:0]        yoe;
		logic [DayW-1:0]   res_day;
		logic [MonthW-1:0] res_mon;
		logic [YearW-1:0]  res_yr;
	} pipe_t;

	// Days before the start of a March-based month (March is 0)
	function automatic logic [8:0] month_off(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Month length for a calendar month
	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DayW-1:0] r;
		case (m)
			MonFeb:                    r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/cad_in_if.sv =====
// Input channel: start date and day count with valid/ready
interface cad_in_if import cad_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DayW-1:0]   in_day;
	logic [MonthW-1:0] in_month;
	logic [YearW-1:0]  in_year;
	logic [CountW-1:0] days_to_add;

	modport source(output valid, in_day, in_month, in_year, days_to_add, input ready);
	modport sink(input valid, in_day, in_month, in_year, days_to_add, output ready);
endinterface

// ===== rtl/cad_out_if.sv =====
// Output channel: result date and validity flag with valid/ready
interface cad_out_if import cad_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DayW-1:0]   out_day;
	logic [MonthW-1:0] out_month;
	logic [YearW-1:0]  out_year;
	logic              date_valid;

	modport source(output valid, out_day, out_month, out_year, date_valid, input ready);
	modport sink(input valid, out_day, out_month, out_year, date_valid, output ready);
endinterface

// ===== rtl/calendar_date_add_days.sv =====
// Gregorian date plus day count, eleven-stage pipeline through an absolute day number.
// A transaction is registered in turn through stages s1 to s11 before its result is offered.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// The last stage is the output register; constant-reciprocal multiplies set the stage split.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload is not reset.
module calendar_date_add_days import cad_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	cad_in_if.sink     in_ch,
	cad_out_if.source  out_ch
);

	logic  adv;
	logic  v_s2, v_s11;
	pipe_t p_in, p_s2, p_s11;

	// Pipeline moves whenever the output register is empty or being drained
	assign adv         = !v_s11 || out_ch.ready;
	assign in_ch.ready = adv;

	always_comb begin
		p_in    = '0;
		p_in.d0 = in_ch.in_day;
		p_in.m0 = in_ch.in_month;
		p_in.y0 = in_ch.in_year;
		p_in.n  = in_ch.days_to_add;
	end

	cad_to_daynum u_to (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.v_in  (in_ch.valid),
		.p_in  (p_in),
		.v_s2  (v_s2),
		.p_s2  (p_s2)
	);

	cad_from_daynum u_from (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.v_in  (v_s2),
		.p_in  (p_s2),
		.v_s11 (v_s11),
		.p_s11 (p_s11)
	);

	// Result transaction
	assign out_ch.valid      = v_s11;
	assign out_ch.out_day    = p_s11.res_day;
	assign out_ch.out_month  = p_s11.res_mon;
	assign out_ch.out_year   = p_s11.res_yr;
	assign out_ch.date_valid = p_s11.ok;

endmodule

// ===== rtl/cad_to_daynum.sv =====
// Front stages: date check and conversion of the start date to a day number plus count
module cad_to_daynum import cad_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  v_in,
	input  pipe_t p_in,
	output logic  v_s2,
	output pipe_t p_s2
);

	logic  v_s1;
	pipe_t p_s1, n1, n2;
	logic [28:0] prod_y, prod_yp;
	logic [13:0] r100;
	logic        leap;

	// Stage 1: year / 100, shifted year and day of shifted year
	always_comb begin
		n1 = p_in;
		prod_y  = 29'(p_in.y0) * 29'(RecipDiv100);
		n1.qy   = prod_y[28:21];
		n1.yp   = 15'(p_in.y0) + 15'(EraYears) - 15'(p_in.m0 <= MonFeb);
		n1.mp   = (p_in.m0 > MonFeb) ? 4'(p_in.m0 - 4'd3) : 4'(p_in.m0 + 4'd9);
		n1.doy  = month_off(n1.mp) + 9'(p_in.d0) - 9'd1;
		prod_yp = 29'(n1.yp) * 29'(RecipDiv100);
		n1.q100 = prod_yp[28:21];
	end

	// Stage 2: leap rule, date check and absolute day number with count added
	always_comb begin
		n2 = p_s1;
		r100 = p_s1.y0 - 14'(14'(p_s1.qy) * 14'd100);
		leap = (r100 == '0) ? (p_s1.qy[1:0] == 2'd0) : (p_s1.y0[1:0] == 2'd0);
		n2.ok = (p_s1.m0 >= 4'd1) && (p_s1.m0 <= MonDec) && (p_s1.d0 >= 5'd1)
			&& (p_s1.d0 <= month_len(p_s1.m0, leap));
		n2.nd = 23'(365) * 23'(p_s1.yp) + 23'(p_s1.yp >> 2) - 23'(p_s1.q100)
			+ 23'(p_s1.q100 >> 2) + 23'(p_s1.doy) + 23'(p_s1.n);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= n1;
			p_s2 <= n2;
		end
	end

endmodule

// ===== rtl/cad_from_daynum.sv =====
// Back stages: conversion of a day number back to a calendar date
module cad_from_daynum import cad_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  v_in,
	input  pipe_t p_in,
	output logic  v_s11,
	output pipe_t p_s11
);

	logic  v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	pipe_t p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9, p_s10;
	pipe_t n3, n4, n5, n6, n7, n8, n9, n10, n11;
	logic [37:0] prod_era;
	logic [31:0] prod_a, prod_b;
	logic [35:0] prod_yoe;
	logic [13:0] prod_yq;
	logic [11:0] v5;
	logic [22:0] prod_mp;
	logic [15:0] yr_full;
	logic [3:0]  mon;

	// Stage 3: era estimate, at most one low
	always_comb begin
		n3 = p_in;
		prod_era = 38'(p_in.nd) * 38'(RecipEra);
		n3.era = prod_era[37:32];
	end

	// Stage 4: remainder against the estimate
	always_comb begin
		n4 = p_s3;
		n4.rem = 19'(p_s3.nd - 23'(p_s3.era) * 23'(EraDays));
	end

	// Stage 5: correct the estimate, giving day of era
	always_comb begin
		n5 = p_s4;
		if (p_s4.rem >= 19'(EraDays)) begin
			n5.era = p_s4.era + 6'd1;
			n5.doe = 18'(p_s4.rem - 19'(EraDays));
		end else begin
			n5.doe = p_s4.rem[17:0];
		end
	end

	// Stage 6: four-year, century and era-end corrections
	always_comb begin
		n6 = p_s5;
		prod_a = 32'(p_s5.doe[17:2]) * 32'(RecipDiv365a);
		prod_b = 32'(p_s5.doe[17:2]) * 32'(RecipDiv9131);
		n6.a = prod_a[30:24];
		n6.b = prod_b[30:28];
		n6.c = (p_s5.doe == 18'(LastDoe));
	end

	// Stage 7: day count scaled to a plain 365-day year
	always_comb begin
		n7 = p_s6;
		n7.t = p_s6.doe - 18'(p_s6.a) + 18'(p_s6.b) - 18'(p_s6.c);
	end

	// Stage 8: year of era
	always_comb begin
		n8 = p_s7;
		prod_yoe = 36'(p_s7.t) * 36'(RecipDiv365b);
		n8.yoe = prod_yoe[34:26];
	end

	// Stage 9: day of shifted year
	always_comb begin
		n9 = p_s8;
		prod_yq = 14'(p_s8.yoe) * 14'(RecipDiv100s);
		n9.doy = 9'(p_s8.doe - (18'(365) * 18'(p_s8.yoe) + 18'(p_s8.yoe >> 2)
			- 18'(prod_yq[13:12])));
	end

	// Stage 10: shifted month
	always_comb begin
		n10 = p_s9;
		v5 = 12'(p_s9.doy) * 12'd5 + 12'd2;
		prod_mp = 23'(v5) * 23'(RecipDiv153);
		n10.mp = prod_mp[21:18];
	end

	// Stage 11: calendar fields, or the start date when it failed the check
	always_comb begin
		n11 = p_s10;
		mon = (p_s10.mp < 4'd10) ? 4'(p_s10.mp + 4'd3) : 4'(p_s10.mp - 4'd9);
		yr_full = 16'(p_s10.era) * 16'(EraYears) + 16'(p_s10.yoe)
			+ 16'(mon <= MonFeb) - 16'(EraYears);
		if (p_s10.ok) begin
			n11.res_day = 5'(p_s10.doy - month_off(p_s10.mp) + 9'd1);
			n11.res_mon = mon;
			n11.res_yr  = yr_full[YearW-1:0];
		end else begin
			n11.res_day = p_s10.d0;
			n11.res_mon = p_s10.m0;
			n11.res_yr  = p_s10.y0;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s3  <= v_in;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3  <= n3;
			p_s4  <= n4;
			p_s5  <= n5;
			p_s6  <= n6;
			p_s7  <= n7;
			p_s8  <= n8;
			p_s9  <= n9;
			p_s10 <= n10;
			p_s11 <= n11;
		end
	end

endmodule

// ===== rtl/cad_checker.sv =====
// Port-level checker for the date adder, with its bind
`include "calendar_date_add_days_macros.svh"

module cad_checker import cad_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DayW-1:0]   out_day,
	input logic [MonthW-1:0] out_month,
	input logic              date_valid
);

	// Stalled result stays offered
	`CAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")

	// Input only held off by a full, stalled output register
	`CAD_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without cause")

	// A summed result has a day of at least one and a month in range
	`CAD_ASSERT_NOW(a_range, out_valid && date_valid,
		out_day >= 5'd1 && out_month >= 4'd1 && out_month <= MonDec, "result date out of range")

	// February never runs past its leap day
	`CAD_ASSERT_NOW(a_feb, out_valid && date_valid && out_month == MonFeb,
		out_day <= 5'd29, "February day too large")

endmodule

bind calendar_date_add_days cad_checker u_cad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_day   (out_ch.out_day),
	.out_month (out_ch.out_month),
	.date_valid(out_ch.date_valid)
);
